>>> hdl/cfq_pkg.sv
`default_nettype none
package cfq_pkg;
	localparam int unsigned DEPTH = 16;
	localparam int unsigned DATA_WIDTH = 32;
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CAP_W = 5;

	localparam logic [1:0] ACT_QUERY = 2'd0;
	localparam logic [1:0] ACT_ENQ = 2'd1;
	localparam logic [1:0] ACT_DEQ = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);
	localparam logic signed [DATA_WIDTH-1:0] EMPTY_VALUE = '1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CAP_W-1:0] cap_t;
	typedef logic signed [DATA_WIDTH-1:0] word_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} st_t;

	typedef struct packed {
		logic success;
		word_t front_value;
		word_t rear_value;
		logic is_empty;
		logic is_full;
	} result_t;

	function automatic cap_t eff_cap(input cap_t cap);
		cap_t c;
		c = cap;
		if (c == '0) c = CAP_W'(1);
		if (c > CAP_W'(DEPTH)) c = CAP_W'(DEPTH);
		return c;
	endfunction

	function automatic idx_t next_idx(input idx_t idx, input cap_t cap);
		logic [IDX_W:0] n;
		n = {1'b0, idx} + (IDX_W+1)'(1);
		if ((CAP_W)'(n) >= eff_cap(cap)) return '0;
		return n[IDX_W-1:0];
	endfunction

	function automatic logic is_full_of(input idx_t head, input idx_t tail, input logic empty,
			input cap_t cap);
		return !empty && (next_idx(tail, cap) == head);
	endfunction
endpackage
`default_nettype wire

>>> hdl/cfq_ram.sv
`default_nettype none
module cfq_ram #(
	parameter int unsigned DEPTH_P = 16,
	parameter int unsigned WIDTH_P = 32
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [$clog2(DEPTH_P)-1:0] wr_addr,
	input wire logic [WIDTH_P-1:0] wr_data,
	input wire logic rd_en,
	input wire logic [$clog2(DEPTH_P)-1:0] rd_addr,
	output logic [WIDTH_P-1:0] rd_data
);
	logic [WIDTH_P-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

>>> hdl/cfq_ctrl.sv
`default_nettype none
module cfq_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfq_pkg::cap_t cap,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] action,
	input wire cfq_pkg::word_t value,
	input wire logic out_free,
	output logic res_valid,
	output cfq_pkg::result_t res
);
	cfq_pkg::st_t state_q, state_d;
	cfq_pkg::idx_t head_q, tail_q, head_d, tail_d;
	logic empty_q, empty_d;
	cfq_pkg::word_t front_q, rear_q, front_d, rear_d;
	logic ok;
	logic wr_en, rd_en;
	cfq_pkg::idx_t wr_addr, rd_addr;
	logic [cfq_pkg::DATA_WIDTH-1:0] rd_data;
	logic accept;

	cfq_ram #(
		.DEPTH_P(cfq_pkg::DEPTH),
		.WIDTH_P(cfq_pkg::DATA_WIDTH)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(value),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign in_ready = (state_q == cfq_pkg::ST_IDLE) && out_free;
	assign accept = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		tail_d = tail_q;
		empty_d = empty_q;
		front_d = front_q;
		rear_d = rear_q;
		ok = 1'b1;
		wr_en = 1'b0;
		wr_addr = tail_q;
		rd_en = 1'b0;
		rd_addr = cfq_pkg::next_idx(head_q, cap);
		res_valid = 1'b0;
		case (state_q)
			cfq_pkg::ST_IDLE: begin
				if (accept) begin
					res_valid = 1'b1;
					case (action)
						cfq_pkg::ACT_ENQ: begin
							if (cfq_pkg::is_full_of(head_q, tail_q, empty_q, cap)) begin
								ok = 1'b0;
							end else begin
								if (empty_q) begin
									head_d = '0;
									tail_d = '0;
									empty_d = 1'b0;
									front_d = value;
								end else begin
									tail_d = cfq_pkg::next_idx(tail_q, cap);
								end
								rear_d = value;
								wr_en = 1'b1;
								wr_addr = tail_d;
							end
						end
						cfq_pkg::ACT_DEQ: begin
							if (empty_q) begin
								ok = 1'b0;
							end else if (head_q == tail_q) begin
								head_d = '0;
								tail_d = '0;
								empty_d = 1'b1;
							end else begin
								head_d = rd_addr;
								rd_en = 1'b1;
								res_valid = 1'b0;
								state_d = cfq_pkg::ST_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			cfq_pkg::ST_READ: begin
				front_d = cfq_pkg::word_t'(rd_data);
				res_valid = 1'b1;
				state_d = cfq_pkg::ST_IDLE;
			end
			default: begin
				state_d = cfq_pkg::ST_IDLE;
			end
		endcase
		res.success = ok;
		res.front_value = empty_d ? cfq_pkg::EMPTY_VALUE : front_d;
		res.rear_value = empty_d ? cfq_pkg::EMPTY_VALUE : rear_d;
		res.is_empty = empty_d;
		res.is_full = cfq_pkg::is_full_of(head_d, tail_d, empty_d, cap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfq_pkg::ST_IDLE;
			head_q <= '0;
			tail_q <= '0;
			empty_q <= 1'b1;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			tail_q <= tail_d;
			empty_q <= empty_d;
		end
	end

	always_ff @(posedge clk) begin
		front_q <= front_d;
		rear_q <= rear_d;
	end
endmodule
`default_nettype wire

>>> hdl/circular_fifo_queue.sv
// Circular FIFO of signed 32-bit words, 16 slots built, usable capacity set by the
// configuration write (0 acts as 1, above 16 acts as 16). Each input transfer carries an
// action in s_tuser (query, enqueue, dequeue; code 3 is a query) and the word in s_tdata,
// and yields exactly one output transfer with the success flag and the queue state after
// the step: front and rear words (-1 when empty), empty and full. Queries, enqueues and
// refused requests are answered in the idle state; a dequeue that leaves entries also
// passes the read state, since the new front word comes from a registered slot memory
// read. The output is registered, so the next transfer is taken while a result waits if
// the result is being taken in that cycle. Write capacity only while the block is idle.
`default_nettype none
module circular_fifo_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [31:0] s_tdata, // value
	input wire logic [1:0] s_tuser, // action
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [63:0] m_tdata, // front_value, rear_value
	output logic [2:0] m_tuser, // success, is_empty, is_full
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [4:0] cfg_data // capacity
);
	cfq_pkg::cap_t cap_q;
	logic out_valid_q;
	cfq_pkg::result_t out_q;
	cfq_pkg::result_t res;
	logic res_valid;
	logic out_free;

	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cfq_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	cfq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cap(cap_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.action(s_tuser),
		.value(cfq_pkg::word_t'(s_tdata)),
		.out_free(out_free),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_q.rear_value, out_q.front_value};
	assign m_tuser = {out_q.is_full, out_q.is_empty, out_q.success};
endmodule
`default_nettype wire

>>> sim/circular_fifo_queue_chk.sv
`timescale 1ns / 1ps
module circular_fifo_queue_chk (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [31:0] s_tdata, // value
	input logic [1:0] s_tuser, // action
	input logic m_tvalid,
	input logic m_tready,
	input logic [63:0] m_tdata, // front_value, rear_value
	input logic [2:0] m_tuser, // success, is_empty, is_full
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [4:0] cfg_data, // capacity
	output int fail_cnt,
	output int pending_cnt,
	output logic [31:0] cap_ok
);
	cfq_pkg::word_t slots [cfq_pkg::DEPTH];
	logic [cfq_pkg::DEPTH-1:0] written;
	cfq_pkg::idx_t head;
	cfq_pkg::idx_t tail;
	logic empty;
	cfq_pkg::cap_t cap;
	cfq_pkg::result_t expected_q [$];
	cfq_pkg::result_t want;

	function automatic int wrap_point(input cfq_pkg::cap_t c);
		if (c == '0) return 1;
		if (int'(c) > int'(cfq_pkg::DEPTH)) return int'(cfq_pkg::DEPTH);
		return int'(c);
	endfunction

	function automatic cfq_pkg::idx_t step_idx(input cfq_pkg::idx_t i, input cfq_pkg::cap_t c);
		if (int'(i) + 1 >= wrap_point(c)) return '0;
		return i + 1'b1;
	endfunction

	function automatic logic queue_at_cap();
		return !empty && (step_idx(tail, cap) == head);
	endfunction

	// advances the queue state by one request and returns the state after it
	function automatic cfq_pkg::result_t serve_request(input logic [1:0] act,
			input cfq_pkg::word_t v);
		cfq_pkg::result_t r;
		r.success = 1'b1;
		case (act)
			cfq_pkg::ACT_ENQ: begin
				if (queue_at_cap()) begin
					r.success = 1'b0;
				end else begin
					if (empty) begin
						head = '0;
						tail = '0;
						empty = 1'b0;
					end else begin
						tail = step_idx(tail, cap);
					end
					slots[tail] = v;
					written[tail] = 1'b1;
				end
			end
			cfq_pkg::ACT_DEQ: begin
				if (empty) begin
					r.success = 1'b0;
				end else if (head == tail) begin
					head = '0;
					tail = '0;
					empty = 1'b1;
				end else begin
					head = step_idx(head, cap);
				end
			end
			default: ;
		endcase
		r.front_value = empty ? cfq_pkg::EMPTY_VALUE : slots[head];
		r.rear_value = empty ? cfq_pkg::EMPTY_VALUE : slots[tail];
		r.is_empty = empty;
		r.is_full = queue_at_cap();
		return r;
	endfunction

	// a new capacity is safe if the head can only walk onto slots already written
	function automatic logic cap_safe(input cfq_pkg::cap_t c);
		cfq_pkg::idx_t i;
		if (empty) return 1'b1;
		i = head;
		for (int k = 0; k < int'(cfq_pkg::DEPTH); k++) begin
			if (i == tail) return 1'b1;
			i = step_idx(i, c);
			if (!written[i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = '0;
			tail = '0;
			empty = 1'b1;
			cap = cfq_pkg::CAP_RESET;
			written = '0;
			expected_q.delete();
			fail_cnt = 0;
			pending_cnt = 0;
			cap_ok = '1;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("%0t: result transfer with none expected, tdata %h tuser %b",
							$time, m_tdata, m_tuser);
				end else begin
					want = expected_q.pop_front();
					if (m_tuser[0] !== want.success || m_tuser[1] !== want.is_empty ||
							m_tuser[2] !== want.is_full ||
							m_tdata[31:0] !== want.front_value ||
							m_tdata[63:32] !== want.rear_value) begin
						fail_cnt++;
						if (fail_cnt <= 10) begin
							$display("%0t: mismatch: exp ok %b front %h rear %h empty %b full %b",
								$time, want.success, want.front_value, want.rear_value,
								want.is_empty, want.is_full);
							$display("%0t: mismatch: got ok %b front %h rear %h empty %b full %b",
								$time, m_tuser[0], m_tdata[31:0], m_tdata[63:32],
								m_tuser[1], m_tuser[2]);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(serve_request(s_tuser, s_tdata));
			if (cfg_valid && cfg_ready)
				cap = cfg_data;
			pending_cnt = expected_q.size();
			for (int c = 0; c < 32; c++)
				cap_ok[c] = cap_safe(cfq_pkg::cap_t'(c));
		end
	end
endmodule

>>> sim/circular_fifo_queue_tb.sv
`timescale 1ns / 1ps
module circular_fifo_queue_tb;
	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0] s_tuser = cfq_pkg::ACT_QUERY;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [2:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [4:0] cfg_data = '0;

	int fail_cnt;
	int pending_cnt;
	logic [31:0] cap_ok;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	logic [4:0] seg_caps [12] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd5, 5'd16, 5'd8,
		5'd3, 5'd15, 5'd1};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	circular_fifo_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	circular_fifo_queue_chk chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.fail_cnt(fail_cnt),
		.pending_cnt(pending_cnt),
		.cap_ok(cap_ok)
	);

	always @(negedge clk) begin
		m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// entered and left at a falling edge
	task automatic push_item(input logic [1:0] act, input logic [31:0] val);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = act;
		s_tdata = val;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid = 1'b0;
		while (pending_cnt != 0) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [4:0] want_cap);
		logic [4:0] cap_sel;
		int tries;
		cap_sel = want_cap;
		tries = 0;
		drain_results();
		// keep the head off slots that were never written
		while (!cap_ok[cap_sel]) begin
			if (tries < 64) begin
				cap_sel = 5'($urandom_range(0, 31));
			end else begin
				push_item(cfq_pkg::ACT_DEQ, $urandom());
				drain_results();
			end
			tries++;
		end
		cfg_valid = 1'b1;
		cfg_data = cap_sel;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_items(input int n, input int enq_pct);
		int r;
		logic [1:0] act;
		logic [31:0] val;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				act = cfq_pkg::ACT_QUERY;
			else if (r < 11)
				act = ACT_SPARE;
			else if (r < 11 + (89 * enq_pct) / 100)
				act = cfq_pkg::ACT_ENQ;
			else
				act = cfq_pkg::ACT_DEQ;
			case ($urandom_range(0, 9))
				0: val = 32'h7FFF_FFFF;
				1: val = 32'h8000_0000;
				2: val = 32'h0000_0000;
				3: val = 32'hFFFF_FFFF;
				default: val = $urandom();
			endcase
			push_item(act, val);
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// capacity 0 behaves as a single slot
		set_capacity(5'd0);
		push_item(cfq_pkg::ACT_QUERY, 32'h0);
		push_item(ACT_SPARE, 32'hFFFF_FFFF);
		push_item(cfq_pkg::ACT_DEQ, 32'h0);
		push_item(cfq_pkg::ACT_ENQ, 32'h7FFF_FFFF);
		push_item(cfq_pkg::ACT_ENQ, 32'h8000_0000);
		push_item(cfq_pkg::ACT_DEQ, 32'h0);

		// capacity above the built depth
		set_capacity(5'd31);
		push_item(cfq_pkg::ACT_ENQ, 32'h0000_0000);
		push_item(cfq_pkg::ACT_ENQ, 32'hFFFF_FFFF);
		push_item(cfq_pkg::ACT_ENQ, 32'hAAAA_AAAA);
		push_item(cfq_pkg::ACT_ENQ, 32'h5555_5555);
		push_item(cfq_pkg::ACT_DEQ, 32'h0);
		push_item(cfq_pkg::ACT_DEQ, 32'h0);

		// shrink while entries are held
		set_capacity(5'd3);
		push_item(cfq_pkg::ACT_ENQ, 32'h1234_5678);
		push_item(cfq_pkg::ACT_ENQ, 32'h0F0F_0F0F);
		push_item(cfq_pkg::ACT_ENQ, 32'h0000_0001);
		push_item(cfq_pkg::ACT_DEQ, 32'h0);
		push_item(cfq_pkg::ACT_DEQ, 32'h0);
		push_item(cfq_pkg::ACT_DEQ, 32'h0);
		push_item(cfq_pkg::ACT_QUERY, 32'h0);

		for (int seg = 0; seg < 16; seg++) begin
			case (seg % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 79;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 79;
				end
				default: begin
					send_idle_pct = 20;
					recv_stall_pct = 20;
				end
			endcase
			set_capacity(seg < 12 ? seg_caps[seg] : 5'($urandom_range(0, 31)));
			random_items(45, 75);
			if (seg == 5)
				drain_results();
			random_items(45, 30);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_cnt == 0 && pending_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
